@@ design/miller_rabin_witness_test_defines.svh @@
// Assertion macros for the Miller-Rabin witness test.
// Simulation builds get the checks. Synthesis builds get empty bodies.
`ifndef MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define MRWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MRWT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`else
`define MRWT_ASSERT(lbl, prop, msg)
`define MRWT_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

@@ design/mrwt_pkg.sv @@
`timescale 1ns / 1ps

package mrwt_pkg;

  // Default operand width in bits.
  localparam int unsigned NUM_BITS_DEF = 63;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_BASECHK,
    ST_SKIP,
    ST_SQR_START,
    ST_SQR_RUN,
    ST_MUL_START,
    ST_MUL_RUN,
    ST_NEXT
  } ctrl_state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED_STEP,
    DP_EXP_INIT,
    DP_EXP_SHIFT,
    DP_SQR_START,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_SQR_END,
    DP_MUL_END
  } dp_op_e;

  // Source of the verdict reported with a result.
  typedef enum logic [1:0] {
    VERD_FALSE,
    VERD_TRUE,
    VERD_EXP
  } verdict_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    dp_op_e   op;
    logic     done;
    verdict_e verdict;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_lt2;
    logic n_is2;
    logic n_even;
    logic red_last;
    logic rem_zero;
    logic e_top;
    logic e_last;
    logic mul_done;
  } dp_status_t;

endpackage

@@ design/mrwt_ctrl.sv @@
`timescale 1ns / 1ps

module mrwt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mrwt_pkg::dp_status_t  status_i,
  output mrwt_pkg::dp_cmd_t     cmd_o,
  output logic                  busy_o
);

  mrwt_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrwt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != mrwt_pkg::ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o.op      = mrwt_pkg::DP_NOP;
    cmd_o.done    = 1'b0;
    cmd_o.verdict = mrwt_pkg::VERD_FALSE;
    unique case (state_q)
      mrwt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = mrwt_pkg::DP_LOAD;
          state_d  = mrwt_pkg::ST_CHECK;
        end
      end
      mrwt_pkg::ST_CHECK: begin
        // Small and even candidates are settled without any arithmetic.
        priority if (status_i.n_lt2) begin
          cmd_o.done    = 1'b1;
          cmd_o.verdict = mrwt_pkg::VERD_FALSE;
          state_d       = mrwt_pkg::ST_IDLE;
        end else if (status_i.n_is2) begin
          cmd_o.done    = 1'b1;
          cmd_o.verdict = mrwt_pkg::VERD_TRUE;
          state_d       = mrwt_pkg::ST_IDLE;
        end else if (status_i.n_even) begin
          cmd_o.done    = 1'b1;
          cmd_o.verdict = mrwt_pkg::VERD_FALSE;
          state_d       = mrwt_pkg::ST_IDLE;
        end else begin
          state_d = mrwt_pkg::ST_REDUCE;
        end
      end
      mrwt_pkg::ST_REDUCE: begin
        cmd_o.op = mrwt_pkg::DP_RED_STEP;
        if (status_i.red_last) begin
          state_d = mrwt_pkg::ST_BASECHK;
        end
      end
      mrwt_pkg::ST_BASECHK: begin
        // A base that is a multiple of the candidate passes trivially.
        if (status_i.rem_zero) begin
          cmd_o.done    = 1'b1;
          cmd_o.verdict = mrwt_pkg::VERD_TRUE;
          state_d       = mrwt_pkg::ST_IDLE;
        end else begin
          cmd_o.op = mrwt_pkg::DP_EXP_INIT;
          state_d  = mrwt_pkg::ST_SKIP;
        end
      end
      mrwt_pkg::ST_SKIP: begin
        // Drop leading zero bits of the exponent.
        if (status_i.e_top) begin
          state_d = mrwt_pkg::ST_SQR_START;
        end else begin
          cmd_o.op = mrwt_pkg::DP_EXP_SHIFT;
        end
      end
      mrwt_pkg::ST_SQR_START: begin
        cmd_o.op = mrwt_pkg::DP_SQR_START;
        state_d  = mrwt_pkg::ST_SQR_RUN;
      end
      mrwt_pkg::ST_SQR_RUN: begin
        if (status_i.mul_done) begin
          cmd_o.op = mrwt_pkg::DP_SQR_END;
          state_d  = status_i.e_top ? mrwt_pkg::ST_MUL_START : mrwt_pkg::ST_NEXT;
        end else begin
          cmd_o.op = mrwt_pkg::DP_MUL_STEP;
        end
      end
      mrwt_pkg::ST_MUL_START: begin
        cmd_o.op = mrwt_pkg::DP_MUL_START;
        state_d  = mrwt_pkg::ST_MUL_RUN;
      end
      mrwt_pkg::ST_MUL_RUN: begin
        if (status_i.mul_done) begin
          cmd_o.op = mrwt_pkg::DP_MUL_END;
          state_d  = mrwt_pkg::ST_NEXT;
        end else begin
          cmd_o.op = mrwt_pkg::DP_MUL_STEP;
        end
      end
      mrwt_pkg::ST_NEXT: begin
        // Move to the next exponent bit, or report once all bits are used.
        cmd_o.op = mrwt_pkg::DP_EXP_SHIFT;
        if (status_i.e_last) begin
          cmd_o.done    = 1'b1;
          cmd_o.verdict = mrwt_pkg::VERD_EXP;
          state_d       = mrwt_pkg::ST_IDLE;
        end else begin
          state_d = mrwt_pkg::ST_SQR_START;
        end
      end
      default: begin
        state_d = mrwt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/mrwt_dp.sv @@
`timescale 1ns / 1ps

module mrwt_dp #(
  parameter int unsigned NUM_BITS = mrwt_pkg::NUM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrwt_pkg::dp_cmd_t     cmd_i,
  input  logic [NUM_BITS-1:0]   candidate_i,
  input  logic [NUM_BITS-1:0]   witness_base_i,
  output mrwt_pkg::dp_status_t  status_o,
  output logic                  done_o,
  output logic                  probable_prime_o
);

  localparam int unsigned W  = NUM_BITS;
  localparam int unsigned CW = $clog2(NUM_BITS);

  // Modular add of two values below n; the carry bit keeps the sum exact.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[W-1:0];
  endfunction

  logic [W-1:0]  n_q, base_sh_q, rem_q, acc_q, ma_q, mb_q, prod_q, e_q;
  logic [CW-1:0] cnt_q;
  logic          fail_q, done_q, result_q;
  logic [W-1:0]  n_m1;
  logic [W:0]    red_shift;
  logic [W-1:0]  red_next;

  assign n_m1      = n_q - W'(1);
  assign red_shift = {rem_q, base_sh_q[W-1]};
  assign red_next  = (red_shift >= {1'b0, n_q}) ? W'(red_shift - {1'b0, n_q})
                                                : red_shift[W-1:0];

  // Status toward the controller. During exponentiation cnt_q counts the exponent
  // shifts, so the last exponent bit sits on top after NUM_BITS - 1 shifts.
  always_comb begin
    status_o.n_lt2    = (n_q[W-1:1] == '0);
    status_o.n_is2    = (n_q == W'(2));
    status_o.n_even   = ~n_q[0];
    status_o.red_last = (cnt_q == CW'(W - 1));
    status_o.rem_zero = (rem_q == '0);
    status_o.e_top    = e_q[W-1];
    status_o.e_last   = (cnt_q == CW'(W - 1));
    status_o.mul_done = (mb_q == '0);
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      mrwt_pkg::DP_NOP: begin
      end
      mrwt_pkg::DP_LOAD: begin
        n_q       <= candidate_i;
        base_sh_q <= witness_base_i;
        rem_q     <= '0;
        cnt_q     <= '0;
      end
      mrwt_pkg::DP_RED_STEP: begin
        // One bit of restoring remainder: base mod n, most significant bit first.
        rem_q     <= red_next;
        base_sh_q <= {base_sh_q[W-2:0], 1'b0};
        cnt_q     <= cnt_q + CW'(1);
      end
      mrwt_pkg::DP_EXP_INIT: begin
        acc_q  <= W'(1);
        e_q    <= n_m1;
        fail_q <= 1'b0;
        cnt_q  <= '0;
      end
      mrwt_pkg::DP_EXP_SHIFT: begin
        e_q   <= {e_q[W-2:0], 1'b0};
        cnt_q <= cnt_q + CW'(1);
      end
      mrwt_pkg::DP_SQR_START: begin
        ma_q   <= acc_q;
        mb_q   <= acc_q;
        prod_q <= '0;
      end
      mrwt_pkg::DP_MUL_START: begin
        ma_q   <= rem_q;
        mb_q   <= acc_q;
        prod_q <= '0;
      end
      mrwt_pkg::DP_MUL_STEP: begin
        // Shift-and-add modular product, one multiplier bit per cycle.
        if (mb_q[0]) begin
          prod_q <= add_mod(prod_q, ma_q, n_q);
        end
        ma_q <= add_mod(ma_q, ma_q, n_q);
        mb_q <= {1'b0, mb_q[W-1:1]};
      end
      mrwt_pkg::DP_SQR_END: begin
        // In the trailing squarings, a root of one other than +-1 proves compositeness.
        acc_q <= prod_q;
        if ((e_q == '0) && (prod_q == W'(1)) && (acc_q != W'(1)) && (acc_q != n_m1)) begin
          fail_q <= 1'b1;
        end
      end
      mrwt_pkg::DP_MUL_END: begin
        acc_q <= prod_q;
      end
      default: begin
      end
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
    end
  end

  // Result value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      unique case (cmd_i.verdict)
        mrwt_pkg::VERD_FALSE: result_q <= 1'b0;
        mrwt_pkg::VERD_TRUE:  result_q <= 1'b1;
        mrwt_pkg::VERD_EXP:   result_q <= ~fail_q && (acc_q == W'(1));
        default:              result_q <= 1'b0;
      endcase
    end
  end

  assign done_o           = done_q;
  assign probable_prime_o = result_q;

endmodule

@@ design/miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps
// Miller-Rabin witness test: one candidate and one base per item. Raise start_i while
// busy_o is low to hand in an item; busy_o stays high until the verdict appears on
// probable_prime_o, qualified by done_o for exactly one cycle. The receiver cannot stall,
// so capture the result in that cycle. Candidates below two and even candidates are
// answered from the check state, without arithmetic. Otherwise the base is reduced modulo
// the candidate one bit at a time, then the candidate minus one is used as exponent,
// most significant bit first: each bit costs one modular squaring and, for a one bit,
// one modular product, each a shift-and-add over the significant bits of its multiplier.
// The bit-serial shift-and-add modular multiplier dominates the run time.
`include "miller_rabin_witness_test_defines.svh"

module miller_rabin_witness_test #(
  parameter int unsigned NUM_BITS = mrwt_pkg::NUM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [NUM_BITS-1:0] candidate_i,
  input  logic [NUM_BITS-1:0] witness_base_i,
  output logic                done_o,
  output logic                probable_prime_o
);

  mrwt_pkg::dp_cmd_t    cmd;
  mrwt_pkg::dp_status_t status;

  // Sequencer.
  mrwt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Modular arithmetic.
  mrwt_dp #(
    .NUM_BITS (NUM_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .candidate_i      (candidate_i),
    .witness_base_i   (witness_base_i),
    .status_o         (status),
    .done_o           (done_o),
    .probable_prime_o (probable_prime_o)
  );

  // A result only follows work on an accepted item.
  `MRWT_ASSERT(a_done_after_busy, !done_o || $past(busy_o), "result without an item in work")
  // One result per item, never two in a row.
  `MRWT_ASSERT_NEXT(a_single_strobe, done_o, !done_o, "result strobe longer than one cycle")
  // An accepted item keeps the block busy on the next cycle.
  `MRWT_ASSERT_NEXT(a_busy_on_accept, start_i && !busy_o, busy_o, "item accepted but not busy")
  // Multiplier steps are issued only while multiplier bits remain.
  `MRWT_ASSERT(a_mul_step_live, (cmd.op != mrwt_pkg::DP_MUL_STEP) || !status.mul_done,
               "multiplier step issued after completion")

endmodule
